@@ rtl/pvfr_pkg.sv @@
`timescale 1ns / 1ps

package pvfr_pkg;

  localparam int RotationSteps = 16;
  localparam int TableLen      = 24;
  localparam int StepCount     = (RotationSteps < TableLen) ? RotationSteps : TableLen;
  localparam int StepIdxW      = $clog2(TableLen);

  localparam int FieldW      = 24;
  localparam int HeadW       = 16;
  localparam int GuardShift  = 8;
  localparam int VecW        = 36;
  localparam int AngW        = 32;
  localparam int QuarterTurn = 16384;

  localparam int GainW    = 31;
  localparam int SplitW   = 18;
  localparam int ProdW    = VecW + GainW;
  localparam int OutShift = 38;
  localparam int RndW     = ProdW - OutShift;
  localparam logic signed [GainW-1:0] GainQ30 = 31'sd652032875;

  localparam logic signed [FieldW-1:0] FieldMax = {1'b0, {(FieldW-1){1'b1}}};
  localparam logic signed [FieldW-1:0] FieldMin = {1'b1, {(FieldW-1){1'b0}}};

  typedef enum logic {
    OP_ROBOT_TO_WORLD = 1'b0,
    OP_WORLD_TO_ROBOT = 1'b1
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [HeadW-1:0]  heading;
    logic signed [FieldW-1:0] in_x;
    logic signed [FieldW-1:0] in_y;
    logic signed [FieldW-1:0] in_yaw;
  } in_beat_t;

  typedef struct packed {
    logic signed [FieldW-1:0] out_x;
    logic signed [FieldW-1:0] out_y;
    logic signed [FieldW-1:0] out_yaw;
    logic                     clipped;
  } out_beat_t;

  typedef struct packed {
    logic signed [VecW-1:0]   x;
    logic signed [VecW-1:0]   y;
    logic signed [AngW-1:0]   z;
    logic signed [FieldW-1:0] yaw;
  } vec_t;

  function automatic logic signed [AngW-1:0] atan_unit(input logic [StepIdxW-1:0] idx);
    logic signed [AngW-1:0] r;
    unique case (idx)
      5'd0:    r = 32'sh20000000;
      5'd1:    r = 32'sh12E4051E;
      5'd2:    r = 32'sh09FB385B;
      5'd3:    r = 32'sh051111D4;
      5'd4:    r = 32'sh028B0D43;
      5'd5:    r = 32'sh0145D7E1;
      5'd6:    r = 32'sh00A2F61E;
      5'd7:    r = 32'sh00517C55;
      5'd8:    r = 32'sh0028BE53;
      5'd9:    r = 32'sh00145F2F;
      5'd10:   r = 32'sh000A2F98;
      5'd11:   r = 32'sh000517CC;
      5'd12:   r = 32'sh00028BE6;
      5'd13:   r = 32'sh000145F3;
      5'd14:   r = 32'sh0000A2FA;
      5'd15:   r = 32'sh0000517D;
      5'd16:   r = 32'sh000028BE;
      5'd17:   r = 32'sh0000145F;
      5'd18:   r = 32'sh00000A30;
      5'd19:   r = 32'sh00000518;
      5'd20:   r = 32'sh0000028C;
      5'd21:   r = 32'sh00000146;
      5'd22:   r = 32'sh000000A3;
      5'd23:   r = 32'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/pvfr_prep.sv @@
`timescale 1ns / 1ps

module pvfr_prep import pvfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_beat_t beat_i,
  output logic     valid_o,
  input  logic     ready_i,
  output vec_t     vec_o
);

  logic                    valid_q;
  vec_t                    vec_q;
  vec_t                    vec_d;
  logic [HeadW-1:0]        ang;
  logic [HeadW-1:0]        ang_f;
  logic signed [HeadW-1:0] ang_s;
  logic                    fold;
  logic signed [VecW-1:0]  xe;
  logic signed [VecW-1:0]  ye;

  always_comb begin
    ang = (beat_i.op == OP_WORLD_TO_ROBOT) ? (HeadW'(0) - beat_i.heading) : beat_i.heading;
    ang_s = $signed(ang);
    fold = (ang_s > HeadW'(QuarterTurn)) || (ang_s < -HeadW'(QuarterTurn));
    ang_f = fold ? (ang + {1'b1, {(HeadW-1){1'b0}}}) : ang;
    xe = VecW'(beat_i.in_x);
    ye = VecW'(beat_i.in_y);
    vec_d.x = (fold ? -xe : xe) <<< GuardShift;
    vec_d.y = (fold ? -ye : ye) <<< GuardShift;
    vec_d.z = $signed({ang_f, {(AngW-HeadW){1'b0}}});
    vec_d.yaw = beat_i.in_yaw;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

@@ rtl/pvfr_cordic_stage.sv @@
`timescale 1ns / 1ps

module pvfr_cordic_stage import pvfr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [StepIdxW-1:0] step_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  vec_t                vec_i,
  output logic                valid_o,
  input  logic                ready_i,
  output vec_t                vec_o
);

  logic                   valid_q;
  vec_t                   vec_q;
  vec_t                   vec_d;
  logic signed [VecW-1:0] dx;
  logic signed [VecW-1:0] dy;
  logic signed [AngW-1:0] da;

  always_comb begin
    dx = vec_i.y >>> step_i;
    dy = vec_i.x >>> step_i;
    da = atan_unit(step_i);
    vec_d.yaw = vec_i.yaw;
    if (!vec_i.z[AngW-1]) begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - da;
    end else begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + da;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

@@ rtl/pvfr_gain.sv @@
`timescale 1ns / 1ps

module pvfr_gain import pvfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  vec_t      vec_i,
  output logic      valid_o,
  input  logic      ready_i,
  output out_beat_t beat_o
);

  localparam int HiW = VecW - SplitW;
  localparam int PpW = HiW + GainW;
  localparam logic signed [ProdW-1:0] RoundBias =
    {{(ProdW-OutShift){1'b0}}, 1'b1, {(OutShift-1){1'b0}}};

  typedef struct packed {
    logic signed [PpW-1:0]    hi_x;
    logic signed [PpW-1:0]    lo_x;
    logic signed [PpW-1:0]    hi_y;
    logic signed [PpW-1:0]    lo_y;
    logic signed [FieldW-1:0] yaw;
  } part_t;

  typedef struct packed {
    logic signed [RndW-1:0]   x;
    logic signed [RndW-1:0]   y;
    logic signed [FieldW-1:0] yaw;
  } rnd_t;

  logic      valid_a_q, valid_b_q, valid_c_q;
  logic      ready_a, ready_b, ready_c;
  part_t     part_q, part_d;
  rnd_t      rnd_q, rnd_d;
  out_beat_t beat_q, beat_d;

  logic signed [ProdW-1:0] prod_x;
  logic signed [ProdW-1:0] prod_y;
  logic                    clip_x;
  logic                    clip_y;

  // partial products, high signed half and low unsigned half
  always_comb begin
    part_d.hi_x = $signed(vec_i.x[VecW-1:SplitW]) * GainQ30;
    part_d.lo_x = $signed({1'b0, vec_i.x[SplitW-1:0]}) * GainQ30;
    part_d.hi_y = $signed(vec_i.y[VecW-1:SplitW]) * GainQ30;
    part_d.lo_y = $signed({1'b0, vec_i.y[SplitW-1:0]}) * GainQ30;
    part_d.yaw  = vec_i.yaw;
  end

  // recombine, round half up, floor shift
  always_comb begin
    prod_x = $signed({part_q.hi_x, {SplitW{1'b0}}}) + ProdW'(part_q.lo_x) + RoundBias;
    prod_y = $signed({part_q.hi_y, {SplitW{1'b0}}}) + ProdW'(part_q.lo_y) + RoundBias;
    rnd_d.x   = prod_x[ProdW-1:OutShift];
    rnd_d.y   = prod_y[ProdW-1:OutShift];
    rnd_d.yaw = part_q.yaw;
  end

  // saturation
  always_comb begin
    clip_x = (rnd_q.x[RndW-1:FieldW-1] != {(RndW-FieldW+1){1'b0}}) &&
             (rnd_q.x[RndW-1:FieldW-1] != {(RndW-FieldW+1){1'b1}});
    clip_y = (rnd_q.y[RndW-1:FieldW-1] != {(RndW-FieldW+1){1'b0}}) &&
             (rnd_q.y[RndW-1:FieldW-1] != {(RndW-FieldW+1){1'b1}});
    beat_d.out_x = clip_x ? (rnd_q.x[RndW-1] ? FieldMin : FieldMax) : rnd_q.x[FieldW-1:0];
    beat_d.out_y = clip_y ? (rnd_q.y[RndW-1] ? FieldMin : FieldMax) : rnd_q.y[FieldW-1:0];
    beat_d.out_yaw = rnd_q.yaw;
    beat_d.clipped = clip_x || clip_y;
  end

  assign ready_c = !valid_c_q || ready_i;
  assign ready_b = !valid_b_q || ready_c;
  assign ready_a = !valid_a_q || ready_b;
  assign ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_q <= valid_i;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
      if (ready_c) begin
        valid_c_q <= valid_b_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      part_q <= part_d;
    end
    if (ready_b && valid_a_q) begin
      rnd_q <= rnd_d;
    end
    if (ready_c && valid_b_q) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_c_q;
  assign beat_o  = beat_q;

endmodule

@@ rtl/planar_velocity_frame_rotation.sv @@
`timescale 1ns / 1ps
// planar velocity frame rotation
// input channel: in_valid_i / in_stall_o carry one beat of op, heading, x, y and
// yaw rate; op selects rotation by +heading (robot to world) or -heading
// (world to robot). output channel: out_valid_o / out_stall_i carry the rotated
// x and y, the unchanged yaw rate and a clipped flag set when either rotated
// component saturated.
// pipeline: one angle fold stage, one register per CORDIC iteration (StepCount,
// 16 at the default), and three gain stages (partial products, round, saturate).
// throughput: one beat per cycle; every stage is a register with its own valid
// bit, so a new beat can enter each cycle while the pipeline moves.
// when the receiver stalls, the output beat holds and upstream stages keep
// filling empty slots; in_stall_o rises only once every stage holds a beat.
// reset clears all valid bits; no state survives between beats.
module planar_velocity_frame_rotation import pvfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic stg_valid [StepCount+1];
  logic stg_ready [StepCount+1];
  vec_t stg_vec   [StepCount+1];
  logic prep_ready;

  pvfr_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (prep_ready),
    .beat_i  (in_beat_i),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .vec_o   (stg_vec[0])
  );

  for (genvar i = 0; i < StepCount; i++) begin : g_step
    pvfr_cordic_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (StepIdxW'(i)),
      .valid_i (stg_valid[i]),
      .ready_o (stg_ready[i]),
      .vec_i   (stg_vec[i]),
      .valid_o (stg_valid[i+1]),
      .ready_i (stg_ready[i+1]),
      .vec_o   (stg_vec[i+1])
    );
  end

  pvfr_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[StepCount]),
    .ready_o (stg_ready[StepCount]),
    .vec_i   (stg_vec[StepCount]),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .beat_o  (out_beat_o)
  );

  assign in_stall_o = !prep_ready;

endmodule

@@ rtl/pvfr_checker.sv @@
`timescale 1ns / 1ps

module pvfr_checker import pvfr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_beat_t  in_beat_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_beat_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_beat_o))
    else $error("output beat changed while stalled");

  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.clipped |->
      (out_beat_o.out_x == FieldMax) || (out_beat_o.out_x == FieldMin) ||
      (out_beat_o.out_y == FieldMax) || (out_beat_o.out_y == FieldMin))
    else $error("clipped flag without a saturated component");

  a_no_stall_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

endmodule

bind planar_velocity_frame_rotation pvfr_checker u_pvfr_checker (.*);

@@ sim/pvfr_rotation_checker.sv @@
`timescale 1ns / 1ps

module pvfr_rotation_checker import pvfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_beat_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_beat_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o
);

  localparam int    AtanLen   = 24;
  localparam int    Steps     = (RotationSteps < AtanLen) ? RotationSteps : AtanLen;
  localparam longint ScaleQ30 = 652032875;

  localparam logic [0:AtanLen-1][31:0] AtanTable = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  out_beat_t expected_rotations_q[$];
  out_beat_t want;
  int        mismatches;
  int        results;

  // returns {saturated, value}
  function automatic logic [FieldW:0] gain_clamp(input longint v);
    longint p;
    p = (v * ScaleQ30 + (longint'(1) << 37)) >>> 38;
    if (p > longint'(FieldMax)) begin
      return {1'b1, FieldMax};
    end
    if (p < longint'(FieldMin)) begin
      return {1'b1, FieldMin};
    end
    return {1'b0, p[FieldW-1:0]};
  endfunction

  function automatic out_beat_t rotate_velocity(input in_beat_t b);
    logic [HeadW-1:0] ang;
    logic [FieldW:0]  gx;
    logic [FieldW:0]  gy;
    longint           x;
    longint           y;
    longint           z;
    longint           dx;
    longint           dy;
    out_beat_t        r;
    int               i;
    ang = b.heading;
    if (b.op == OP_WORLD_TO_ROBOT) begin
      ang = -ang;
    end
    x = b.in_x;
    y = b.in_y;
    z = longint'($signed(ang));
    // fold into the right half plane
    if (z > QuarterTurn || z < -QuarterTurn) begin
      x = -x;
      y = -y;
      ang = ang + 16'h8000;
      z = longint'($signed(ang));
    end
    z = z * 65536;
    x = x * 256;
    y = y * 256;
    for (i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(AtanTable[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(AtanTable[i]);
      end
    end
    gx = gain_clamp(x);
    gy = gain_clamp(y);
    r.out_x   = gx[FieldW-1:0];
    r.out_y   = gy[FieldW-1:0];
    r.out_yaw = b.in_yaw;
    r.clipped = gx[FieldW] | gy[FieldW];
    return r;
  endfunction

  task automatic compare_field(input string name, input logic signed [FieldW-1:0] exp_v,
                               input logic signed [FieldW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_rotations_q.delete();
      mismatches = 0;
      results = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rotations_q.size() == 0) begin
          $error("result beat with no rotation outstanding: x %0d y %0d",
                 out_beat_i.out_x, out_beat_i.out_y);
          mismatches++;
        end else begin
          want = expected_rotations_q.pop_front();
          compare_field("out_x", want.out_x, out_beat_i.out_x);
          compare_field("out_y", want.out_y, out_beat_i.out_y);
          compare_field("out_yaw", want.out_yaw, out_beat_i.out_yaw);
          compare_field("clipped", {23'd0, want.clipped}, {23'd0, out_beat_i.clipped});
          results++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_rotations_q.push_back(rotate_velocity(in_beat_i));
      end
      fail_count_o <= mismatches;
      pending_o <= expected_rotations_q.size();
      checked_o <= results;
    end
  end

endmodule

@@ sim/tb_planar_velocity_frame_rotation.sv @@
`timescale 1ns / 1ps

module tb_planar_velocity_frame_rotation;
  import pvfr_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 64;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  int fail_count;
  int pending;
  int checked;
  int sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  planar_velocity_frame_rotation DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  pvfr_rotation_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_beat_i   (out_beat),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic in_beat_t make_beat(input op_e op, input int heading, input int x,
                                         input int y, input int yaw);
    in_beat_t b;
    b.op      = op;
    b.heading = 16'(heading);
    b.in_x    = 24'(x);
    b.in_y    = 24'(y);
    b.in_yaw  = 24'(yaw);
    return b;
  endfunction

  function automatic logic signed [FieldW-1:0] random_component(input int kind);
    case (kind)
      0: begin
        return 24'($urandom);
      end
      1: begin
        return 24'($signed(12'($urandom)));
      end
      default: begin
        if ($urandom_range(1) == 1) begin
          return FieldMax - 24'($urandom_range(255));
        end
        return FieldMin + 24'($urandom_range(255));
      end
    endcase
  endfunction

  function automatic in_beat_t random_motion();
    in_beat_t b;
    b.op      = op_e'($urandom_range(1));
    b.heading = 16'($urandom);
    // near the fold and wrap boundaries
    if ($urandom_range(7) == 0) begin
      b.heading = 16'($urandom_range(3) * 16384 + $urandom_range(4) - 2);
    end
    b.in_x   = random_component($urandom_range(2));
    b.in_y   = random_component($urandom_range(2));
    b.in_yaw = 24'($urandom);
    return b;
  endfunction

  task automatic drive_motion(input in_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sent++;
  endtask

  task automatic settle_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    idle_pct = idle;
    stall_pct <= stall;
    repeat (count) begin
      drive_motion(random_motion());
    end
    settle_results();
  endtask

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats: quadrant edges, wrap of -pi, saturation, field extremes
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, 0, 1000, -2000, 5));
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, 16384, FieldMax, FieldMin, FieldMax));
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, 16385, 4096, 8192, FieldMin));
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, -16384, -4096, 8192, 1));
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, -16385, 32768, -32768, -1));
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, 32767, FieldMax, FieldMax, FieldMin));
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, -32768, 12345, -6789, 0));
    drive_motion(make_beat(OP_WORLD_TO_ROBOT, -32768, 12345, -6789, 0));
    drive_motion(make_beat(OP_WORLD_TO_ROBOT, 0, FieldMin, FieldMin, FieldMax));
    drive_motion(make_beat(OP_WORLD_TO_ROBOT, 16384, 100000, 200000, 7));
    drive_motion(make_beat(OP_WORLD_TO_ROBOT, -16385, -100000, 300000, -7));
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, 8192, FieldMax, FieldMax, 42));
    drive_motion(make_beat(OP_WORLD_TO_ROBOT, 8192, FieldMin, FieldMax, -42));
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, -8192, FieldMin, FieldMin, 3));
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, 0, 0, 0, 0));
    drive_motion(make_beat(OP_WORLD_TO_ROBOT, 32767, -1, -1, -1));
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, 1, 1, 0, 24'hAAAAAA));
    drive_motion(make_beat(OP_WORLD_TO_ROBOT, -1, 0, 1, 24'h555555));
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, 24576, FieldMax, 0, 11));
    drive_motion(make_beat(OP_WORLD_TO_ROBOT, -24576, 0, FieldMin, -11));
    drive_motion(make_beat(OP_WORLD_TO_ROBOT, 16383, FieldMax, FieldMin, 9));
    drive_motion(make_beat(OP_ROBOT_TO_WORLD, -16383, FieldMin, FieldMax, -9));

    run_phase(0, 0, 200);
    run_phase(84, 0, 200);
    run_phase(0, 84, 200);
    run_phase(23, 23, 200);

    repeat (DrainCycles) @(posedge clk);

    $display("%0d velocity beats sent, %0d rotated results compared", sent, checked);
    $display("both directions, wrapped headings, saturation, idle and stalled handshakes");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
